// File: sv/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg - shared types and constants of the sound trigger unit
// Item formats, command codes, status codes and register indexes used by the
// classifier, the queue, the executor and the top level.
// ----------------------------------------------------------------------------
package cst_pkg;

  // field widths
  localparam int ID_W     = 29;
  localparam int LEN_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int HOLD_W   = 16;
  localparam int STATUS_W = 2;
  localparam int LINES    = 5;
  localparam int SHOTS    = 3;

  // default width of the elapsed counters
  localparam int ELAPSED_BITS_DEFAULT = 16;

  // depth of the queue between classifier and executor
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = ID_W;
  localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_FRAME_ID = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KNOCK_FRAME_ID   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS       = 2'd2;

  // register reset values
  localparam logic [ID_W-1:0]   COMMAND_FRAME_ID_RESET = 29'd256;
  localparam logic [ID_W-1:0]   KNOCK_FRAME_ID_RESET   = 29'd257;
  localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET       = 16'd3000;

  // operation of an input item
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // emotion codes
  localparam logic [BYTE_W-1:0] CODE_NONE    = 8'd0;
  localparam logic [BYTE_W-1:0] CODE_JOY     = 8'd1;
  localparam logic [BYTE_W-1:0] CODE_RAIN    = 8'd2;
  localparam logic [BYTE_W-1:0] CODE_THUNDER = 8'd3;
  localparam logic [BYTE_W-1:0] CODE_SHUFFLE = 8'd4;
  localparam logic [BYTE_W-1:0] CODE_KNOCK   = 8'd5;

  // first byte that marks a valid knock event
  localparam logic [BYTE_W-1:0] KNOCK_EVENT = 8'd1;

  // one-shot lanes: 0 knock, 1 joy, 2 shuffle
  localparam logic [BYTE_W-1:0] SHOT_CODE [SHOTS] = '{CODE_KNOCK, CODE_JOY, CODE_SHUFFLE};

  // line level bits
  localparam int LV_THUNDER   = 0;
  localparam int LV_RAIN      = 1;
  localparam int LV_SHOT_BASE = 2;

  // item status codes
  localparam logic [STATUS_W-1:0] ST_IGNORED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_APPLIED    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SUPPRESSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TICK       = 2'd3;

  typedef struct packed {
    logic              operation;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] first_byte;
  } in_item_t;

  typedef struct packed {
    logic                thunder_line_n;
    logic                rain_line_n;
    logic                knock_line_n;
    logic                joy_line_n;
    logic                shuffle_line_n;
    logic [STATUS_W-1:0] item_status;
  } out_item_t;

  // classified item handed from front to back
  typedef enum logic [1:0] {
    CMD_IGNORE,
    CMD_APPLY,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] code;
  } cmd_t;

  // handshake between queue and executor
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// File: sv/can_command_sound_trigger_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_command_sound_trigger_unit - CAN driven sound relay controller
// Classifies received frames and millisecond ticks and drives five
// active-low relay lines, one result item per input item.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while in_stall is low and returns
// one result item for each, carrying the five line levels after the item and
// a status code. An item goes through the classifier into a two-entry queue,
// then through the executor into the output register. The executor takes the
// queue head while the output register is free or being emptied, so an output
// stall holds the flow. The user must write registers only while no item is
// in flight; the block itself does not enforce this.
module can_command_sound_trigger_unit #(
  parameter int ELAPSED_BITS = cst_pkg::ELAPSED_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cst_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cst_pkg::out_item_t               out_item,
  input  logic                             cfg_we,
  input  logic [cst_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cst_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cst_pkg::*;

  logic [ID_W-1:0]   command_frame_id;
  logic [ID_W-1:0]   knock_frame_id;
  logic [HOLD_W-1:0] hold_ticks;

  cmd_t        front_cmd;
  logic        queue_full;
  logic        queue_pop;
  queue_head_t queue_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      command_frame_id <= COMMAND_FRAME_ID_RESET;
      knock_frame_id   <= KNOCK_FRAME_ID_RESET;
      hold_ticks       <= HOLD_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COMMAND_FRAME_ID: command_frame_id <= cfg_data[ID_W-1:0];
        REG_KNOCK_FRAME_ID:   knock_frame_id   <= cfg_data[ID_W-1:0];
        REG_HOLD_TICKS:       hold_ticks       <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = queue_full;

  // classifier
  cst_front u_front (
    .item             (in_item),
    .command_frame_id (command_frame_id),
    .knock_frame_id   (knock_frame_id),
    .cmd              (front_cmd)
  );

  // queue between classifier and executor
  cst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid),
    .push_cmd (front_cmd),
    .full     (queue_full),
    .pop      (queue_pop),
    .head     (queue_head)
  );

  // executor and output register
  cst_back #(
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (queue_head),
    .pop        (queue_pop),
    .hold_ticks (hold_ticks),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

// File: sv/cst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_front - frame classifier
// Matches the frame identifier against the two configured identifiers and
// turns each item into a tick, an ignored frame or a code to apply.
// ----------------------------------------------------------------------------
module cst_front (
  input  cst_pkg::in_item_t           item,
  input  logic [cst_pkg::ID_W-1:0]    command_frame_id,
  input  logic [cst_pkg::ID_W-1:0]    knock_frame_id,
  output cst_pkg::cmd_t               cmd
);
  import cst_pkg::*;

  // classification; command identifier wins when both are equal
  always_comb begin
    cmd.kind = CMD_IGNORE;
    cmd.code = CODE_NONE;
    priority if (item.operation == OP_TICK) begin
      cmd.kind = CMD_TICK;
    end else if (item.frame_length != '0) begin
      priority if (item.frame_id == command_frame_id) begin
        cmd.kind = CMD_APPLY;
        cmd.code = item.first_byte;
      end else if (item.frame_id == knock_frame_id && item.first_byte == KNOCK_EVENT) begin
        cmd.kind = CMD_APPLY;
        cmd.code = CODE_KNOCK;
      end else begin
        cmd.kind = CMD_IGNORE;
      end
    end else begin
      cmd.kind = CMD_IGNORE;
    end
  end

endmodule

// File: sv/cst_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_queue - short command queue
// Small circular buffer that decouples the classifier from the executor.
// ----------------------------------------------------------------------------
module cst_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cst_pkg::cmd_t       push_cmd,
  output logic                full,
  input  logic                pop,
  output cst_pkg::queue_head_t head
);
  import cst_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: sv/cst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_back - command executor
// Holds the one-shot counters, busy flags and line levels, applies codes and
// ticks, and presents each result item in an output register.
// ----------------------------------------------------------------------------
module cst_back #(
  parameter int ELAPSED_BITS = cst_pkg::ELAPSED_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cst_pkg::queue_head_t         head,
  output logic                         pop,
  input  logic [cst_pkg::HOLD_W-1:0]   hold_ticks,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cst_pkg::out_item_t           out_item
);
  import cst_pkg::*;

  localparam int CMP_W = (ELAPSED_BITS > HOLD_W) ? ELAPSED_BITS : HOLD_W;
  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

  logic [ELAPSED_BITS-1:0] elapsed      [SHOTS];
  logic [ELAPSED_BITS-1:0] elapsed_next [SHOTS];
  logic [SHOTS-1:0]        busy_flags;
  logic [SHOTS-1:0]        busy_flags_next;
  logic [LINES-1:0]        line_levels;
  logic [LINES-1:0]        line_levels_next;
  logic [STATUS_W-1:0]     status;

  logic [SHOTS-1:0]        match;
  logic [SHOTS-1:0]        running;
  logic [SHOTS-1:0]        expired_tick;
  logic [SHOTS-1:0]        busy_cleared;
  logic [ELAPSED_BITS-1:0] elapsed_inc [SHOTS];
  logic [CMP_W-1:0]        hold_ext;
  logic                    suppress;
  logic [BYTE_W-1:0]       code;

  // take the next item when the output register is free or being emptied
  assign pop  = head.valid && (!out_valid || !out_stall);
  assign code = head.cmd.code;
  assign hold_ext = CMP_W'(hold_ticks);

  // per-lane comparisons
  always_comb begin
    for (int i = 0; i < SHOTS; i++) begin
      match[i]        = (code == SHOT_CODE[i]);
      running[i]      = busy_flags[i] && (CMP_W'(elapsed[i]) < hold_ext);
      elapsed_inc[i]  = (elapsed[i] == ELAPSED_MAX) ? elapsed[i]
                                                    : elapsed[i] + ELAPSED_BITS'(1);
      expired_tick[i] = busy_flags[i] && (CMP_W'(elapsed_inc[i]) >= hold_ext);
    end
    suppress     = |(match & running);
    busy_cleared = busy_flags & ~match;
  end

  // state update for one item
  always_comb begin
    busy_flags_next  = busy_flags;
    line_levels_next = line_levels;
    for (int i = 0; i < SHOTS; i++) begin
      elapsed_next[i] = elapsed[i];
    end
    status = ST_IGNORED;
    unique case (head.cmd.kind)
      CMD_TICK: begin
        status = ST_TICK;
        for (int i = 0; i < SHOTS; i++) begin
          elapsed_next[i] = elapsed_inc[i];
          if (expired_tick[i]) begin
            line_levels_next[LV_SHOT_BASE + i] = 1'b1;
            busy_flags_next[i] = 1'b0;
          end
        end
      end
      CMD_APPLY: begin
        if (suppress) begin
          status = ST_SUPPRESSED;
        end else begin
          status = ST_APPLIED;
          busy_flags_next = busy_cleared;
          // release idle lines and, for other non-zero codes, busy ones too
          for (int i = 0; i < SHOTS; i++) begin
            if (!busy_cleared[i] || (!match[i] && code != CODE_NONE)) begin
              line_levels_next[LV_SHOT_BASE + i] = 1'b1;
            end
          end
          // latched lines
          if (code != CODE_THUNDER && code != CODE_RAIN) begin
            line_levels_next[LV_THUNDER] = 1'b1;
            line_levels_next[LV_RAIN]    = 1'b1;
          end
          if (code == CODE_RAIN) begin
            line_levels_next[LV_RAIN] = 1'b0;
          end else if (code == CODE_THUNDER) begin
            line_levels_next[LV_THUNDER] = 1'b0;
          end
          // start the matching one-shot
          for (int i = 0; i < SHOTS; i++) begin
            if (match[i] && !busy_cleared[i]) begin
              line_levels_next[LV_SHOT_BASE + i] = 1'b0;
              elapsed_next[i] = '0;
              busy_flags_next[i] = 1'b1;
            end
          end
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_flags  <= '0;
      line_levels <= '1;
      for (int i = 0; i < SHOTS; i++) begin
        elapsed[i] <= '0;
      end
    end else if (pop) begin
      busy_flags  <= busy_flags_next;
      line_levels <= line_levels_next;
      for (int i = 0; i < SHOTS; i++) begin
        elapsed[i] <= elapsed_next[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.thunder_line_n <= line_levels_next[LV_THUNDER];
      out_item.rain_line_n    <= line_levels_next[LV_RAIN];
      out_item.knock_line_n   <= line_levels_next[LV_SHOT_BASE];
      out_item.joy_line_n     <= line_levels_next[LV_SHOT_BASE + 1];
      out_item.shuffle_line_n <= line_levels_next[LV_SHOT_BASE + 2];
      out_item.item_status    <= status;
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the CAN sound trigger unit
// Drives CAN frames and millisecond ticks through the valid/stall input,
// keeps a shadow of the relay lines, one-shot timers and registers, and
// compares each result item field by field with that shadow or a typed row.
// A directed table runs first, then a tick run up to a one-shot's hold time,
// then random phases under varied register settings, most idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import cst_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 200;
  localparam int REPORT_LIMIT   = 200;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 220;
  localparam int ELAPSED_BITS   = ELAPSED_BITS_DEFAULT;

  localparam logic [ELAPSED_BITS-1:0] ELAPSED_TOP   = '1;
  localparam logic [ID_W-1:0]         ID_TOP        = '1;
  localparam logic [HOLD_W-1:0]       HOLD_TOP      = '1;
  localparam logic [HOLD_W-1:0]       TICK_RUN_HOLD = 16'd150;

  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_TYPED,
    ROW_SETUP
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    in_item_t          item;
    out_item_t         want;
    logic [ID_W-1:0]   cmd_id;
    logic [ID_W-1:0]   knock_id;
    logic [HOLD_W-1:0] hold;
  } stim_row_t;

  // clock, reset and block ports
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_COMMAND_FRAME_ID;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // shadow of the unit state and registers
  logic [ELAPSED_BITS-1:0] shot_elapsed [SHOTS];
  logic [SHOTS-1:0]        shot_busy;
  logic [LINES-1:0]        relay_levels;
  logic [ID_W-1:0]         cur_cmd_id;
  logic [ID_W-1:0]         cur_knock_id;
  logic [HOLD_W-1:0]       cur_hold;

  out_item_t pending_levels [$];
  stim_row_t stim_rows [$];
  bit        idle_on = 1'b0;
  int        fails   = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  can_command_sound_trigger_unit #(
    .ELAPSED_BITS(ELAPSED_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow state after reset
  function automatic void relay_reset();
    int i;
    for (i = 0; i < SHOTS; i++) shot_elapsed[i] = '0;
    shot_busy    = '0;
    relay_levels = '1;
    cur_cmd_id   = COMMAND_FRAME_ID_RESET;
    cur_knock_id = KNOCK_FRAME_ID_RESET;
    cur_hold     = HOLD_TICKS_RESET;
  endfunction

  // one emotion code applied to the lines
  function automatic logic [STATUS_W-1:0] relay_apply(input logic [BYTE_W-1:0] code);
    int i;
    // a repeat on a line still inside its hold time is dropped
    for (i = 0; i < SHOTS; i++)
      if (code == SHOT_CODE[i] && shot_busy[i] && shot_elapsed[i] < cur_hold)
        return ST_SUPPRESSED;
    // an expired line of the same code is freed before it retriggers
    for (i = 0; i < SHOTS; i++)
      if (code == SHOT_CODE[i]) shot_busy[i] = 1'b0;
    // idle lines and busy lines of another non-zero code go off
    for (i = 0; i < SHOTS; i++)
      if (!shot_busy[i] || (code != SHOT_CODE[i] && code != CODE_NONE))
        relay_levels[LV_SHOT_BASE + i] = 1'b1;
    if (code != CODE_THUNDER && code != CODE_RAIN) begin
      relay_levels[LV_THUNDER] = 1'b1;
      relay_levels[LV_RAIN]    = 1'b1;
    end
    if (code == CODE_RAIN) begin
      relay_levels[LV_RAIN] = 1'b0;
    end else if (code == CODE_THUNDER) begin
      relay_levels[LV_THUNDER] = 1'b0;
    end
    // start the one-shot of this code
    for (i = 0; i < SHOTS; i++)
      if (code == SHOT_CODE[i] && !shot_busy[i]) begin
        relay_levels[LV_SHOT_BASE + i] = 1'b0;
        shot_elapsed[i] = '0;
        shot_busy[i]    = 1'b1;
      end
    return ST_APPLIED;
  endfunction

  // millisecond tick: saturating timers, release on expiry
  function automatic void relay_tick();
    int i;
    for (i = 0; i < SHOTS; i++) begin
      if (shot_elapsed[i] != ELAPSED_TOP) shot_elapsed[i] = shot_elapsed[i] + 1'b1;
      if (shot_busy[i] && shot_elapsed[i] >= cur_hold) begin
        relay_levels[LV_SHOT_BASE + i] = 1'b1;
        shot_busy[i] = 1'b0;
      end
    end
  endfunction

  // result item expected for one input item
  function automatic out_item_t relay_predict(input in_item_t it);
    out_item_t            r;
    logic [STATUS_W-1:0]  st;
    st = ST_IGNORED;
    if (it.operation == OP_TICK) begin
      relay_tick();
      st = ST_TICK;
    end else if (it.frame_length != '0) begin
      if (it.frame_id == cur_cmd_id) begin
        st = relay_apply(it.first_byte);
      end else if (it.frame_id == cur_knock_id && it.first_byte == KNOCK_EVENT) begin
        st = relay_apply(CODE_KNOCK);
      end
    end
    r.thunder_line_n = relay_levels[LV_THUNDER];
    r.rain_line_n    = relay_levels[LV_RAIN];
    r.knock_line_n   = relay_levels[LV_SHOT_BASE];
    r.joy_line_n     = relay_levels[LV_SHOT_BASE + 1];
    r.shuffle_line_n = relay_levels[LV_SHOT_BASE + 2];
    r.item_status    = st;
    return r;
  endfunction

  function automatic in_item_t mk_item(input logic op, input logic [ID_W-1:0] id,
                                       input logic [LEN_W-1:0] len,
                                       input logic [BYTE_W-1:0] b);
    in_item_t it;
    it.operation    = op;
    it.frame_id     = id;
    it.frame_length = len;
    it.first_byte   = b;
    return it;
  endfunction

  function automatic stim_row_t item_row(input logic op, input logic [ID_W-1:0] id,
                                         input logic [LEN_W-1:0] len,
                                         input logic [BYTE_W-1:0] b);
    stim_row_t r;
    r.kind = ROW_PRED;
    r.item = mk_item(op, id, len, b);
    r.want = '0;
    return r;
  endfunction

  // lines are given as {thunder, rain, knock, joy, shuffle}
  function automatic stim_row_t typed_row(input logic op, input logic [ID_W-1:0] id,
                                          input logic [LEN_W-1:0] len,
                                          input logic [BYTE_W-1:0] b,
                                          input logic [LINES-1:0] lines,
                                          input logic [STATUS_W-1:0] st);
    stim_row_t r;
    r.kind = ROW_TYPED;
    r.item = mk_item(op, id, len, b);
    r.want = out_item_t'({lines, st});
    return r;
  endfunction

  function automatic stim_row_t setup_row(input logic [ID_W-1:0] cmd_id,
                                          input logic [ID_W-1:0] knock_id,
                                          input logic [HOLD_W-1:0] hold);
    stim_row_t r;
    r.kind     = ROW_SETUP;
    r.cmd_id   = cmd_id;
    r.knock_id = knock_id;
    r.hold     = hold;
    return r;
  endfunction

  // mostly well-formed frames and ticks, some stray traffic
  function automatic in_item_t random_item();
    int                 pick;
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  b;
    pick = $urandom_range(99);
    id   = ID_W'($urandom);
    len  = LEN_W'($urandom_range(1, 15));
    b    = BYTE_W'($urandom);
    if (pick < 35) return mk_item(OP_TICK, id, LEN_W'($urandom), b);
    if (pick < 75) begin
      if ($urandom_range(4) != 0) b = BYTE_W'($urandom_range(0, 5));
      return mk_item(OP_FRAME, cur_cmd_id, len, b);
    end
    if (pick < 90) begin
      if ($urandom_range(3) != 0) b = KNOCK_EVENT;
      return mk_item(OP_FRAME, cur_knock_id, len, b);
    end
    // empty frames on a live identifier, or unknown identifiers
    if ($urandom_range(1) == 0) return mk_item(OP_FRAME, cur_cmd_id, '0, b);
    return mk_item(OP_FRAME, id, LEN_W'($urandom), b);
  endfunction

  // offer one item, wait for it to be taken, queue its expected result
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want,
                           output out_item_t result);
    out_item_t guess;
    if (idle_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    guess  = relay_predict(it);
    result = typed ? want : guess;
    pending_levels.push_back(result);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers while the unit is idle
  task automatic configure(input logic [ID_W-1:0] cmd_id, input logic [ID_W-1:0] knock_id,
                           input logic [HOLD_W-1:0] hold);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_COMMAND_FRAME_ID;
    cfg_data  <= CFG_DATA_W'(cmd_id);
    @(posedge clk);
    cfg_index <= REG_KNOCK_FRAME_ID;
    cfg_data  <= CFG_DATA_W'(knock_id);
    @(posedge clk);
    cfg_index <= REG_HOLD_TICKS;
    cfg_data  <= CFG_DATA_W'(hold);
    @(posedge clk);
    cfg_we       <= 1'b0;
    cur_cmd_id   = cmd_id;
    cur_knock_id = knock_id;
    cur_hold     = hold;
  endtask

  task automatic random_setup();
    logic [ID_W-1:0]   c;
    logic [ID_W-1:0]   k;
    logic [HOLD_W-1:0] h;
    case ($urandom_range(3))
      0: c = ID_TOP;
      1: c = '0;
      default: c = ID_W'($urandom);
    endcase
    case ($urandom_range(3))
      0: k = c;
      1: k = c ^ ID_W'(1);
      default: k = ID_W'($urandom);
    endcase
    case ($urandom_range(9))
      0: h = HOLD_W'(1);
      1: h = HOLD_TOP;
      2: h = HOLD_W'($urandom_range(1, 65535));
      3, 4: h = HOLD_W'($urandom_range(9, 60));
      default: h = HOLD_W'($urandom_range(1, 8));
    endcase
    configure(c, k, h);
  endtask

  function automatic void check_field(input string name, input logic [STATUS_W-1:0] want,
                                      input logic [STATUS_W-1:0] got);
    if (got !== want) begin
      fails++;
      // keep the log readable when the unit is badly off
      if (fails <= REPORT_LIMIT) $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  // result check, output stall bursts and watchdog
  always @(posedge clk) begin : result_side
    out_item_t due;
    int        stall_left;
    int        quiet_cycles;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_levels.size() == 0) begin
        fails++;
        $error("result item with no expectation waiting");
      end else begin
        due = pending_levels.pop_front();
        check_field("thunder_line_n", due.thunder_line_n, out_item.thunder_line_n);
        check_field("rain_line_n", due.rain_line_n, out_item.rain_line_n);
        check_field("knock_line_n", due.knock_line_n, out_item.knock_line_n);
        check_field("joy_line_n", due.joy_line_n, out_item.joy_line_n);
        check_field("shuffle_line_n", due.shuffle_line_n, out_item.shuffle_line_n);
        check_field("item_status", due.item_status, out_item.item_status);
      end
    end
    // receiver stalls in bursts while idling is on
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(99) < 15) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
    // nothing moving on either side for too long
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall == 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int        ph;
    int        done;
    out_item_t seen;
    relay_reset();

    // directed table, reset register values first
    stim_rows.push_back(typed_row(OP_TICK, '0, '0, '0, 5'b11111, ST_TICK));
    stim_rows.push_back(typed_row(OP_FRAME, COMMAND_FRAME_ID_RESET, 4'd0, CODE_JOY,
                                  5'b11111, ST_IGNORED));
    stim_rows.push_back(typed_row(OP_FRAME, COMMAND_FRAME_ID_RESET, 4'd1, CODE_JOY,
                                  5'b11101, ST_APPLIED));
    stim_rows.push_back(typed_row(OP_FRAME, COMMAND_FRAME_ID_RESET, 4'd8, CODE_JOY,
                                  5'b11101, ST_SUPPRESSED));
    stim_rows.push_back(item_row(OP_FRAME, KNOCK_FRAME_ID_RESET, 4'd1, KNOCK_EVENT));
    stim_rows.push_back(item_row(OP_FRAME, KNOCK_FRAME_ID_RESET, 4'd8, CODE_NONE));
    stim_rows.push_back(item_row(OP_FRAME, COMMAND_FRAME_ID_RESET, 4'd15, CODE_SHUFFLE));
    stim_rows.push_back(item_row(OP_TICK, '0, '0, '0));
    stim_rows.push_back(item_row(OP_FRAME, COMMAND_FRAME_ID_RESET, 4'd1, CODE_RAIN));
    stim_rows.push_back(item_row(OP_FRAME, COMMAND_FRAME_ID_RESET, 4'd2, CODE_THUNDER));
    stim_rows.push_back(item_row(OP_FRAME, COMMAND_FRAME_ID_RESET, 4'd1, CODE_NONE));
    stim_rows.push_back(item_row(OP_FRAME, COMMAND_FRAME_ID_RESET, 4'd1, CODE_KNOCK));
    stim_rows.push_back(item_row(OP_FRAME, COMMAND_FRAME_ID_RESET, 4'd1, '1));
    stim_rows.push_back(item_row(OP_FRAME, '0, 4'd1, CODE_JOY));
    stim_rows.push_back(item_row(OP_FRAME, ID_TOP, '1, '1));
    stim_rows.push_back(item_row(OP_TICK, ID_TOP, '1, '1));
    // shorter hold while lines are still busy: expired retrigger
    stim_rows.push_back(setup_row(COMMAND_FRAME_ID_RESET, KNOCK_FRAME_ID_RESET, 16'd1));
    stim_rows.push_back(item_row(OP_FRAME, COMMAND_FRAME_ID_RESET, 4'd1, CODE_JOY));
    stim_rows.push_back(item_row(OP_TICK, '0, '0, '0));
    // equal identifiers at the top, zero hold
    stim_rows.push_back(setup_row(ID_TOP, ID_TOP, '0));
    stim_rows.push_back(item_row(OP_FRAME, ID_TOP, 4'd1, CODE_KNOCK));
    stim_rows.push_back(item_row(OP_FRAME, ID_TOP, 4'd1, CODE_KNOCK));
    stim_rows.push_back(item_row(OP_FRAME, ID_TOP, 4'd1, KNOCK_EVENT));
    stim_rows.push_back(item_row(OP_TICK, '0, '0, '0));
    // longest hold, then an unknown code and fresh one-shots
    stim_rows.push_back(setup_row('0, ID_W'(5), HOLD_TOP));
    stim_rows.push_back(item_row(OP_FRAME, '0, 4'd1, 8'd6));
    stim_rows.push_back(item_row(OP_FRAME, ID_W'(5), 4'd1, KNOCK_EVENT));
    stim_rows.push_back(item_row(OP_FRAME, '0, 4'd1, CODE_JOY));

    repeat (RESET_CYCLES) @(posedge clk);
    rst     <= 1'b0;
    idle_on = 1'b1;

    foreach (stim_rows[k]) begin
      if (stim_rows[k].kind == ROW_SETUP) begin
        configure(stim_rows[k].cmd_id, stim_rows[k].knock_id, stim_rows[k].hold);
      end else begin
        send_item(stim_rows[k].item, stim_rows[k].kind == ROW_TYPED, stim_rows[k].want, seen);
      end
    end

    // tick a running one-shot up to its hold: repeat just before expiry, then release
    idle_on = 1'b0;
    configure(cur_cmd_id, cur_knock_id, TICK_RUN_HOLD);
    repeat (int'(TICK_RUN_HOLD) - 1)
      send_item(mk_item(OP_TICK, ID_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom)),
                1'b0, '0, seen);
    send_item(mk_item(OP_FRAME, cur_cmd_id, 4'd1, CODE_JOY), 1'b0, '0, seen);
    repeat (3) send_item(mk_item(OP_TICK, '0, '0, '0), 1'b0, '0, seen);

    // random phases; phase 3 and the last run without idling on either side
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      random_setup();
      idle_on = (ph != 3) && (ph != RAND_PHASES - 1);
      done    = 0;
      while (done < PHASE_ITEMS) begin
        send_item(random_item(), 1'b0, '0, seen);
        if (seen.item_status != ST_IGNORED) done++;
      end
    end

    drain();
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/cst_pkg.sv
sv/cst_front.sv
sv/cst_queue.sv
sv/cst_back.sv
sv/can_command_sound_trigger_unit.sv
verif/testbench.sv
